[rtl/first_fit_heap_allocator_unit_defines.svh]
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FFHA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ffha_pkg.sv]
`default_nettype none

package ffha_pkg;

  localparam int unsigned CFG_AW = 3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NULL    = 3'd1,
    ST_NOMEM   = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] request_size;
    logic [15:0] free_address;
  } in_t;

  typedef struct packed {
    logic [15:0] data_address;
    status_t     status;
  } out_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
    logic        is_free;
  } entry_t;

endpackage

`default_nettype wire

[rtl/first_fit_heap_allocator_unit.sv]
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | in_data   (mode, request_size, free_address)
// out     | output    | out_valid/out_stall | out_data (data_address, status)
// cfg     | input     | APB write/read    | heap_base @0x0, heap_limit @0x4
//
// An item runs through these steps, the table holding up to MAX_BLOCKS entries:
// accept, one read per entry on the table memory read port, a decision when no
// entry matches, and the hand-over of the result to the output register.
// Null requests skip the reads. in_stall stays high from accept until the hand-over.
// Reset: synchronous, rst_n low; table contents stay undefined, count and top clear.
// A stalled result waits in the output register while the next transaction is taken.
`default_nettype none

`include "first_fit_heap_allocator_unit_defines.svh"

module first_fit_heap_allocator_unit #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire ffha_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output ffha_pkg::out_t                     out_data,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [ffha_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);

  logic [15:0] heap_base_r;
  logic [15:0] heap_limit_r;
  logic        cfg_wr;
  logic        base_load;

  logic             eng_res_valid;
  ffha_pkg::out_t   eng_res_data;
  logic             res_take;
  logic             out_valid_r;
  ffha_pkg::out_t   out_data_r;

  logic             tbl_rd_en;
  logic [IDX_W-1:0] tbl_rd_addr;
  ffha_pkg::entry_t tbl_rd_data;
  logic             tbl_wr_en;
  logic [IDX_W-1:0] tbl_wr_addr;
  ffha_pkg::entry_t tbl_wr_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign base_load  = cfg_wr && (cfg_paddr[ffha_pkg::CFG_AW-1] == ffha_pkg::REG_HEAP_BASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= 16'h0000;
      heap_limit_r <= 16'hFFFF;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[ffha_pkg::CFG_AW-1])
        ffha_pkg::REG_HEAP_BASE:  heap_base_r  <= cfg_pwdata[15:0];
        ffha_pkg::REG_HEAP_LIMIT: heap_limit_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[ffha_pkg::CFG_AW-1])
      ffha_pkg::REG_HEAP_BASE:  cfg_prdata = {16'h0000, heap_base_r};
      ffha_pkg::REG_HEAP_LIMIT: cfg_prdata = {16'h0000, heap_limit_r};
      default:                  cfg_prdata = 32'h0;
    endcase
  end

  ffha_engine #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .IDX_W        (IDX_W)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .heap_limit  (heap_limit_r),
    .base_load   (base_load),
    .base_value  (cfg_pwdata[15:0]),
    .res_valid   (eng_res_valid),
    .res_data    (eng_res_data),
    .res_take    (res_take),
    .tbl_rd_en   (tbl_rd_en),
    .tbl_rd_addr (tbl_rd_addr),
    .tbl_rd_data (tbl_rd_data),
    .tbl_wr_en   (tbl_wr_en),
    .tbl_wr_addr (tbl_wr_addr),
    .tbl_wr_data (tbl_wr_data)
  );

  ffha_table_ram #(
    .DEPTH (MAX_BLOCKS),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data)
  );

  // hold the result until the far side takes it
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && res_take) begin
      out_data_r <= eng_res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FFHA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "engine idle after accept")
  `FFHA_ASSERT_SAME(a_no_accept_with_result, in_valid && !in_stall, !eng_res_valid, "accept while result pending")
  `FFHA_ASSERT_NEXT(a_result_loads, eng_res_valid && res_take, out_valid && (out_data == $past(eng_res_data)), "result lost on load")
  `FFHA_ASSERT_SAME(a_addr_only_on_ok, out_valid && (out_data.data_address != 16'h0), out_data.status == ffha_pkg::ST_OK, "address on failed transaction")

endmodule

`default_nettype wire

[rtl/ffha_table_ram.sv]
`default_nettype none

module ffha_table_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output ffha_pkg::entry_t     rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire ffha_pkg::entry_t wr_data
);

  ffha_pkg::entry_t mem [DEPTH];
  ffha_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/ffha_engine.sv]
`default_nettype none

module ffha_engine #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 5,
  parameter int unsigned IDX_W        = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ffha_pkg::in_t     in_data,
  input  wire logic [15:0]       heap_limit,
  input  wire logic              base_load,
  input  wire logic [15:0]       base_value,
  output logic                   res_valid,
  output ffha_pkg::out_t         res_data,
  input  wire logic              res_take,
  output logic                   tbl_rd_en,
  output logic [IDX_W-1:0]       tbl_rd_addr,
  input  wire ffha_pkg::entry_t  tbl_rd_data,
  output logic                   tbl_wr_en,
  output logic [IDX_W-1:0]       tbl_wr_addr,
  output ffha_pkg::entry_t       tbl_wr_data
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);
  localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);
  localparam logic [17:0] HDR18 = 18'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic             mode_r, mode_nxt;
  logic [15:0]      size_r, size_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [16:0]      top_r, top_nxt;
  ffha_pkg::out_t   res_r, res_nxt;

  logic        hit;
  logic        is_last;
  logic [17:0] new_top;

  always_comb begin
    if (mode_r == ffha_pkg::MODE_ALLOC) begin
      hit = tbl_rd_data.is_free && (tbl_rd_data.length >= size_r);
    end else begin
      hit = (({1'b0, tbl_rd_data.start} + HDR17) == {1'b0, addr_r});
    end
    is_last = ((CNT_W'(cmp_idx_r) + CNT_ONE) == count_r);
    new_top = {1'b0, top_r} + HDR18 + {2'b00, size_r};
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    size_nxt    = size_r;
    addr_nxt    = addr_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    pend_nxt    = pend_r;
    count_nxt   = count_r;
    top_nxt     = top_r;
    res_nxt     = res_r;
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = rd_idx_r[IDX_W-1:0];
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = cmp_idx_r;
    tbl_wr_data = tbl_rd_data;
    unique case (state_r)
      S_IDLE: begin
        if (base_load && (count_r == '0)) begin
          top_nxt = {1'b0, base_value};
        end
        if (in_valid) begin
          mode_nxt    = in_data.mode;
          size_nxt    = in_data.request_size;
          addr_nxt    = in_data.free_address;
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = '0;
          rd_idx_nxt  = CNT_ONE;
          cmp_idx_nxt = '0;
          pend_nxt    = (count_r != '0);
          if (((in_data.mode == ffha_pkg::MODE_ALLOC) && (in_data.request_size == 16'h0)) ||
              ((in_data.mode == ffha_pkg::MODE_FREE) && (in_data.free_address == 16'h0))) begin
            res_nxt.data_address = 16'h0;
            res_nxt.status       = ffha_pkg::ST_NULL;
            state_nxt            = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pend_r && hit) begin
          pend_nxt       = 1'b0;
          state_nxt      = S_DONE;
          res_nxt.status = ffha_pkg::ST_OK;
          if (mode_r == ffha_pkg::MODE_ALLOC) begin
            tbl_wr_en            = 1'b1;
            tbl_wr_data.is_free  = 1'b0;
            res_nxt.data_address = tbl_rd_data.start + HDR16;
          end else begin
            res_nxt.data_address = 16'h0;
            if (is_last) begin
              top_nxt   = top_r - HDR17 - {1'b0, tbl_rd_data.length};
              count_nxt = count_r - CNT_ONE;
            end else begin
              tbl_wr_en           = 1'b1;
              tbl_wr_data.is_free = 1'b1;
            end
          end
        end else if (rd_idx_r < count_r) begin
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = rd_idx_r[IDX_W-1:0];
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + CNT_ONE;
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt             = 1'b0;
          state_nxt            = S_DONE;
          res_nxt.data_address = 16'h0;
          if (mode_r == ffha_pkg::MODE_FREE) begin
            res_nxt.status = ffha_pkg::ST_UNKNOWN;
          end else if (count_r >= CNT_MAX) begin
            res_nxt.status = ffha_pkg::ST_FULL;
          end else if (new_top > {2'b00, heap_limit}) begin
            res_nxt.status = ffha_pkg::ST_NOMEM;
          end else begin
            tbl_wr_en            = 1'b1;
            tbl_wr_addr          = count_r[IDX_W-1:0];
            tbl_wr_data.start    = top_r[15:0];
            tbl_wr_data.length   = size_r;
            tbl_wr_data.is_free  = 1'b0;
            res_nxt.data_address = top_r[15:0] + HDR16;
            res_nxt.status       = ffha_pkg::ST_OK;
            top_nxt              = new_top[16:0];
            count_nxt            = count_r + CNT_ONE;
          end
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      count_r <= '0;
      top_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
      top_r   <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    size_r    <= size_nxt;
    addr_r    <= addr_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

endmodule

`default_nettype wire
